// File: hdl/rgpl_pkg.sv
// Shared types and codes for the grid point locator.
`timescale 1ns / 1ps
package rgpl_pkg;

  localparam int unsigned COORD_W = 32;
  localparam int unsigned FRAC_W  = 16;
  localparam int unsigned CNT_W   = 12;
  localparam int unsigned DIVD_W  = COORD_W + FRAC_W;
  localparam int unsigned OUT_ID_W = 24;
  localparam int unsigned CFG_W   = 36;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_OUTSIDE  = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_BADCOUNT = 3'd3,
    ST_BEYOND   = 3'd4
  } status_e;

  typedef enum logic {
    CMD_LOAD   = 1'b0,
    CMD_LOCATE = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    CFG_NUM_DIMS = 3'd0,
    CFG_COUNTS   = 3'd1,
    CFG_ORIGIN_X = 3'd2,
    CFG_ORIGIN_Y = 3'd3,
    CFG_ORIGIN_Z = 3'd4,
    CFG_SIZE_X   = 3'd5,
    CFG_SIZE_Y   = 3'd6,
    CFG_SIZE_Z   = 3'd7
  } cfg_idx_e;

  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_DIV,
    S_MUL1,
    S_MUL2,
    S_LOOK,
    S_FIN
  } state_e;

  // what one axis lane hands to the merge logic
  typedef struct packed {
    logic                busy;
    logic                neg;
    logic [COORD_W-1:0]  cnum;
    logic [FRAC_W-1:0]   frac;
  } lane_res_t;

endpackage

// File: hdl/rgpl_in_if.sv
// Input channel: one point or centroid per transfer.
`timescale 1ns / 1ps
interface rgpl_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [31:0] x;
  logic [31:0] y;
  logic [31:0] z;
  logic [23:0] elem_id;

  modport source (output valid, cmd, x, y, z, elem_id, input ready);
  modport sink   (input valid, cmd, x, y, z, elem_id, output ready);
endinterface

// File: hdl/rgpl_out_if.sv
// Output channel: one lookup result per transfer.
`timescale 1ns / 1ps
interface rgpl_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [23:0] found_id;
  logic [11:0] cell_index;
  logic [15:0] frac_x;
  logic [15:0] frac_y;
  logic [15:0] frac_z;

  modport source (output valid, status, found_id, cell_index, frac_x, frac_y, frac_z,
                  input ready);
  modport sink   (input valid, status, found_id, cell_index, frac_x, frac_y, frac_z,
                  output ready);
endinterface

// File: hdl/rgpl_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module rgpl_ram #(
  parameter int unsigned WIDTH = 25,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: hdl/rgpl_lane.sv
// One axis lane: offset from origin, then a radix-2 divide by the cell size.
`timescale 1ns / 1ps
module rgpl_lane
  import rgpl_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [COORD_W-1:0] coord_i,
  input  logic [COORD_W-1:0] origin_i,
  input  logic [COORD_W-1:0] size_i,
  output lane_res_t          res_o
);

  localparam int unsigned STEP_W = $clog2(DIVD_W + 1);

  logic [STEP_W-1:0]  step_q, step_d;
  logic [DIVD_W-1:0]  shr_q, shr_d;
  logic [COORD_W-1:0] rem_q, rem_d;
  logic [COORD_W-1:0] div_q;
  logic               neg_q;
  logic [COORD_W:0]   off;
  logic [COORD_W:0]   trial;
  logic [COORD_W:0]   diff;

  assign off   = {coord_i[COORD_W-1], coord_i} - {origin_i[COORD_W-1], origin_i};
  assign trial = {rem_q, shr_q[DIVD_W-1]};
  assign diff  = trial - {1'b0, div_q};

  always_comb begin
    step_d = step_q;
    shr_d  = shr_q;
    rem_d  = rem_q;
    if (start_i) begin
      step_d = STEP_W'(DIVD_W);
      shr_d  = {off[COORD_W-1:0], {FRAC_W{1'b0}}};
      rem_d  = '0;
    end else if (step_q != '0) begin
      // shift the next dividend bit in, keep the quotient bit at the bottom
      step_d = step_q - 1'b1;
      if (!diff[COORD_W]) begin
        rem_d = diff[COORD_W-1:0];
        shr_d = {shr_q[DIVD_W-2:0], 1'b1};
      end else begin
        rem_d = trial[COORD_W-1:0];
        shr_d = {shr_q[DIVD_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else begin
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shr_q <= shr_d;
    rem_q <= rem_d;
    if (start_i) begin
      div_q <= size_i;
      neg_q <= off[COORD_W];
    end
  end

  assign res_o.busy = (step_q != '0);
  assign res_o.neg  = neg_q;
  assign res_o.cnum = shr_q[DIVD_W-1:FRAC_W];
  assign res_o.frac = shr_q[FRAC_W-1:0];

endmodule

// File: hdl/regular_grid_point_locator_core.sv
// Top level: config registers, three axis lanes, index merge and the element table.
//
//  channel  dir  handshake        payload
//  in_if    in   valid / ready    cmd, x, y, z, elem_id
//  out_if   out  valid / ready    status, found_id, cell_index, frac_x/y/z
//  cfg      in   cfg_we_i         cfg_idx_i, cfg_wdata_i
//
// An item passes from its transfer through the axis lanes (48 divide steps, then a
// hand-over), two multiply-add steps for the row-major index, a status and table read
// step and a result step. The next transfer is accepted only once the previous item
// has left its result step. After reset the table sweep clears one entry per cycle,
// all TABLE_DEPTH entries, with in_if.ready low. The result register lets the next
// item in while a result waits; the block holds in its last cycle only if the
// previous result is still not taken.
`timescale 1ns / 1ps
module regular_grid_point_locator_core
  import rgpl_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 4096,
  parameter int unsigned ID_BITS     = 24
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [2:0]       cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  rgpl_in_if.sink          in_if,
  rgpl_out_if.source       out_if
);

  localparam int unsigned AW    = $clog2(TABLE_DEPTH);
  localparam int unsigned IDX_W = 3 * CNT_W;

  // configuration
  logic [1:0]         dims_q;
  logic [CFG_W-1:0]   counts_q;
  logic [COORD_W-1:0] origin_q [3];
  logic [COORD_W-1:0] size_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dims_q   <= 2'd3;
      counts_q <= CFG_W'(16781313);
      for (int i = 0; i < 3; i++) begin
        origin_q[i] <= '0;
        size_q[i]   <= COORD_W'(65536);
      end
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_NUM_DIMS: dims_q      <= cfg_wdata_i[1:0];
        CFG_COUNTS:   counts_q    <= cfg_wdata_i;
        CFG_ORIGIN_X: origin_q[0] <= cfg_wdata_i[COORD_W-1:0];
        CFG_ORIGIN_Y: origin_q[1] <= cfg_wdata_i[COORD_W-1:0];
        CFG_ORIGIN_Z: origin_q[2] <= cfg_wdata_i[COORD_W-1:0];
        CFG_SIZE_X:   size_q[0]   <= cfg_wdata_i[COORD_W-1:0];
        CFG_SIZE_Y:   size_q[1]   <= cfg_wdata_i[COORD_W-1:0];
        CFG_SIZE_Z:   size_q[2]   <= cfg_wdata_i[COORD_W-1:0];
        default: ;
      endcase
    end
  end

  logic [CNT_W-1:0] cnt [3];
  logic [2:0]       used;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cnt[i] = counts_q[i*CNT_W +: CNT_W];
    end
    used[0] = 1'b1;
    used[1] = (dims_q >= 2'd2);
    used[2] = (dims_q == 2'd3);
  end

  // control
  state_e state_q, state_d;
  logic   in_xfer, out_xfer, lanes_busy;
  logic   cmd_q;
  logic [OUT_ID_W-1:0] id_q;
  logic [IDX_W-1:0]    acc_q, acc_d;
  status_e             st_q, st_d;
  logic [AW-1:0]       clr_q, clr_d;

  assign in_if.ready = (state_q == S_IDLE);
  assign in_xfer     = in_if.valid & in_if.ready;
  assign out_xfer    = out_if.valid & out_if.ready;

  // lanes
  lane_res_t          res [3];
  logic [COORD_W-1:0] coord [3];
  assign coord[0] = in_if.x;
  assign coord[1] = in_if.y;
  assign coord[2] = in_if.z;

  for (genvar g = 0; g < 3; g++) begin : g_lane
    rgpl_lane u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .start_i  (in_xfer),
      .coord_i  (coord[g]),
      .origin_i (origin_q[g]),
      .size_i   (size_q[g]),
      .res_o    (res[g])
    );
  end

  assign lanes_busy = res[0].busy | res[1].busy | res[2].busy;

  // merge of the lane findings
  logic bad, outside, beyond;
  always_comb begin
    bad     = 1'b0;
    outside = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (used[i]) begin
        bad     = bad | (cnt[i] == '0) | (size_q[i] == '0);
        outside = outside | res[i].neg | (res[i].cnum >= COORD_W'(cnt[i]));
      end
    end
    beyond = (acc_q >= IDX_W'(TABLE_DEPTH));
  end

  // table: valid bit on top of the id
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [ID_BITS:0]  ram_wdata, ram_rdata;
  logic              load_ok;

  rgpl_ram #(
    .WIDTH (ID_BITS + 1),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (acc_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  // result register
  logic                ov_q;
  status_e             ost_q;
  logic [OUT_ID_W-1:0] oid_q;
  logic [CNT_W-1:0]    oidx_q;
  logic [FRAC_W-1:0]   ofr_q [3];
  logic                out_load;

  assign load_ok  = (state_q == S_FIN) && (!ov_q || out_if.ready);
  assign out_load = load_ok;

  always_comb begin
    state_d   = state_q;
    acc_d     = acc_q;
    st_d      = st_q;
    clr_d     = clr_q;
    ram_we    = 1'b0;
    ram_waddr = acc_q[AW-1:0];
    ram_wdata = {1'b1, ID_BITS'(id_q)};
    case (state_q)
      S_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + 1'b1;
        if (clr_q == AW'(TABLE_DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_xfer) begin
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (!lanes_busy) begin
          acc_d   = IDX_W'(res[0].cnum[CNT_W-1:0]);
          state_d = S_MUL1;
        end
      end
      S_MUL1: begin
        if (used[1]) begin
          acc_d = IDX_W'(24'(acc_q[CNT_W-1:0]) * 24'(cnt[1]) + 24'(res[1].cnum[CNT_W-1:0]));
        end
        state_d = S_MUL2;
      end
      S_MUL2: begin
        if (used[2]) begin
          acc_d = IDX_W'(acc_q[23:0]) * IDX_W'(cnt[2]) + IDX_W'(res[2].cnum[CNT_W-1:0]);
        end
        state_d = S_LOOK;
      end
      S_LOOK: begin
        if (bad) begin
          st_d = ST_BADCOUNT;
        end else if (outside) begin
          st_d = ST_OUTSIDE;
        end else if (beyond) begin
          st_d = ST_BEYOND;
        end else begin
          st_d = ST_OK;
        end
        state_d = S_FIN;
      end
      S_FIN: begin
        if (load_ok) begin
          ram_we  = (cmd_q == CMD_LOAD) && (st_q == ST_OK);
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      clr_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      if (out_load) begin
        ov_q <= 1'b1;
      end else if (out_xfer) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    st_q  <= st_d;
    if (in_xfer) begin
      cmd_q <= in_if.cmd;
      id_q  <= in_if.elem_id;
    end
    if (out_load) begin
      if (st_q != ST_OK) begin
        ost_q  <= st_q;
        oid_q  <= '0;
        oidx_q <= '0;
        for (int i = 0; i < 3; i++) begin
          ofr_q[i] <= '0;
        end
      end else begin
        oidx_q <= acc_q[CNT_W-1:0];
        for (int i = 0; i < 3; i++) begin
          ofr_q[i] <= used[i] ? res[i].frac : '0;
        end
        if (cmd_q == CMD_LOAD) begin
          ost_q <= ST_OK;
          oid_q <= '0;
        end else if (!ram_rdata[ID_BITS]) begin
          ost_q <= ST_EMPTY;
          oid_q <= '0;
        end else begin
          ost_q <= ST_OK;
          oid_q <= OUT_ID_W'(ram_rdata[ID_BITS-1:0]);
        end
      end
    end
  end

  assign out_if.valid      = ov_q;
  assign out_if.status     = ost_q;
  assign out_if.found_id   = oid_q;
  assign out_if.cell_index = oidx_q;
  assign out_if.frac_x     = ofr_q[0];
  assign out_if.frac_y     = ofr_q[1];
  assign out_if.frac_z     = ofr_q[2];

  // table writes happen only in the sweep or when a result is stored
  a_ram_we_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_CLR || state_q == S_FIN))
    else $error("table written outside sweep or result cycle");

  a_lanes_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> lanes_busy)
    else $error("lanes idle after an accepted item");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && (ost_q == ST_OUTSIDE || ost_q == ST_BADCOUNT || ost_q == ST_BEYOND))
      |-> (oid_q == '0 && oidx_q == '0))
    else $error("error result carries nonzero id or index");

endmodule
